// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of the sorter.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define ESORT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sorter assertion failed");

// Precondition in one cycle implies a consequence in the next cycle.
`define ESORT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sorter assertion failed");

`endif

// ----- hw/rtl/esort_pkg.sv -----
// Shared types and constants of the exchange sorter.
// Used by the controller, the datapath and the top level; no dependencies.
package esort_pkg;

  localparam int DataW = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ins;  // insert the accepted input value into the sorted row
    logic pop;  // move the smallest entry into the output register
  } esort_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic one_left;  // exactly one value remains in the row
  } esort_sts_t;

endpackage

// ----- hw/rtl/esort_ctrl.sv -----
// Controller of the exchange sorter: load and drain phases, handshakes.
// Depends on esort_pkg for the command and status structs.
module esort_ctrl
  import esort_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       last_i,
  input  logic       out_stall_i,
  input  esort_sts_t sts_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output esort_cmd_t cmd_o
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   pop;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == ST_LOAD);
  // The output register is free when empty or when its beat is taken now.
  assign pop         = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall_i);

  assign cmd_o.ins = accept;
  assign cmd_o.pop = pop;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        if (accept && last_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pop && sts_i.one_left) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/esort_dp.sv -----
// Datapath of the exchange sorter: sorted row of cells, count, output register.
// Depends on esort_pkg for the command and status structs.
module esort_dp
  import esort_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  esort_cmd_t              cmd_i,
  input  logic signed [DataW-1:0] value_i,
  output esort_sts_t              sts_o,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    last_res_o,
  output logic                    overflow_o
);

  localparam int CntW = $clog2(MAX_ITEMS + 1);

  logic signed [DataW-1:0] store_q [MAX_ITEMS];
  logic signed [DataW-1:0] store_d [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]    lt;
  logic [CntW-1:0]         count_q, count_d;
  logic                    dropped_q, dropped_d;
  logic signed [DataW-1:0] out_value_q;
  logic                    out_last_q, out_ovf_q;
  logic                    do_ins;
  logic                    full;

  // The row holds the maximum number of values.
  assign full           = (count_q == CntW'(MAX_ITEMS));
  assign sts_o.one_left = (count_q == CntW'(1));
  assign do_ins         = cmd_i.ins && !full;

  // Each cell compares the incoming value with its own entry. Cells at or
  // beyond the fill level act as larger than anything, so the lt vector is
  // all zeros then all ones, and the new value lands at the first one.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    assign lt[i] = (CntW'(i) < count_q) ? (value_i < store_q[i]) : 1'b1;

    always_comb begin
      store_d[i] = store_q[i];
      if (cmd_i.pop) begin
        if (i < MAX_ITEMS - 1) begin
          store_d[i] = store_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
        end
      end else if (do_ins && (CntW'(i) <= count_q) && lt[i]) begin
        if (i > 0) begin
          store_d[i] = lt[(i > 0) ? i - 1 : 0] ? store_q[(i > 0) ? i - 1 : 0] : value_i;
        end else begin
          store_d[i] = value_i;
        end
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
      if (sts_o.one_left) begin
        dropped_d = 1'b0;
      end
    end else if (cmd_i.ins) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      store_q[i] <= store_d[i];
    end
    if (cmd_i.pop) begin
      out_value_q <= store_q[0];
      out_last_q  <= sts_o.one_left;
      out_ovf_q   <= dropped_q;
    end
  end

  assign sorted_value_o = out_value_q;
  assign last_res_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

// ----- hw/rtl/exchange_sorter.sv -----
// Top level of the exchange sorter: joins the controller and the datapath.
// Depends on esort_pkg, esort_ctrl and esort_dp.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   value_i, last_i
//   out      output     out_valid_o / out_stall_i sorted_value_o, last_res_o, overflow_o
//
// While a set is loading, one input beat is taken every cycle; each value is
// placed into the sorted row of cells in the cycle it arrives.
// After the closing beat the input stalls; the kept values then leave through
// the output register one per cycle, held back by any output stall.
// The first input beat of the next set is taken in the cycle after the last
// result enters the output register, even while that result still waits.
// Reset clears the fill count, the overflow flag and the valid state; no
// clearing pass is needed, since only entries written in the current set
// are ever read.
module exchange_sorter
  import esort_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    last_res_o,
  output logic                    overflow_o
);

  // Commands flow from the controller to the datapath, status flows back.
  esort_cmd_t cmd;
  esort_sts_t sts;

  esort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // The datapath holds the sorted row, the fill count, the overflow flag
  // and the output register that keeps a waiting beat steady under stall.
  esort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (value_i),
    .sts_o          (sts),
    .sorted_value_o (sorted_value_o),
    .last_res_o     (last_res_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ----- hw/rtl/esort_checker.sv -----
// Port-level checker of the exchange sorter, bound to the top level.
// Depends on esort_pkg and assert_macros.svh.
`include "assert_macros.svh"

module esort_checker
  import esort_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    last_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [DataW-1:0] sorted_value_o,
  input logic                    last_res_o,
  input logic                    overflow_o
);

  logic                    out_take_mid;
  logic                    out_held;
  logic                    in_close;
  logic                    no_descent;
  logic signed [DataW-1:0] prev_value_q;

  assign out_take_mid = out_valid_o && !out_stall_i && !last_res_o;
  assign out_held     = out_valid_o && out_stall_i;
  assign in_close     = in_valid_i && !in_stall_o && last_i;
  assign no_descent   = out_valid_o && (sorted_value_o >= prev_value_q);

  // Result value seen at the previous edge.
  always_ff @(posedge clk_i) begin
    prev_value_q <= sorted_value_o;
  end

  // A stalled result beat holds.
  `ESORT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(sorted_value_o))
  // Once a set is closed, the input stalls.
  `ESORT_ASSERT_NEXT(a_close_stalls, clk_i, rst_ni, in_close, in_stall_o)
  // Within a set the results follow without gaps and never descend.
  `ESORT_ASSERT_NEXT(a_ascending, clk_i, rst_ni, out_take_mid, no_descent)
  // The overflow mark is the same on every result of a set.
  `ESORT_ASSERT_NEXT(a_ovf_steady, clk_i, rst_ni, out_take_mid, overflow_o == $past(overflow_o))

endmodule

bind exchange_sorter esort_checker u_esort_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .last_i         (last_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sorted_value_o (sorted_value_o),
  .last_res_o     (last_res_o),
  .overflow_o     (overflow_o)
);
